/* rtl/core/mbdt_pkg.sv */
package mbdt_pkg;

    localparam int NUM_SLOTS = 32;
    // handles are 6 bits wide, so slot 64 can never be named
    localparam int USABLE    = (NUM_SLOTS < 63) ? NUM_SLOTS : 63;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int MODE_W    = 2;
    localparam int PIN_W     = 6;
    localparam int TIME_W    = 40;
    localparam int LOCK_W    = 16;
    localparam int KEY_W     = 16;
    localparam int HANDLE_W  = 6;

    localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(USABLE - 1);
    localparam logic [HANDLE_W-1:0] MAX_HANDLE = HANDLE_W'(USABLE);

    localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd2;

    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_CREATE = 1'b1;

endpackage

/* rtl/core/multi_button_debounce_table_unit.sv */
// channel | signals                          | direction | handshake
// --------+----------------------------------+-----------+-------------------------------
// item    | mode pin level now_ms            | in        | item_valid / item_ready
//         | debounce_ms key handle           |           |
// result  | kind button pressed stamp_ms     | out       | result_valid / result_ready
//         | event_pin event_key              |           |
//
// Destroy completes in the idle state on acceptance. Create and edge walk the slot
// table one slot a cycle; edge then enters a check state for the 40-bit elapsed-time
// subtract and lockout compare. A result waits there until the output register is free.
// Reset frees every slot at once; no clearing pass is needed.
// item_ready is high only while the sequencer is idle. A finished word waits in
// the output register; the sequencer holds before writing the next one into it.
module multi_button_debounce_table_unit
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [mbdt_pkg::MODE_W-1:0]    mode,
    input  logic [mbdt_pkg::PIN_W-1:0]     pin,
    input  logic                           level,
    input  logic [mbdt_pkg::TIME_W-1:0]    now_ms,
    input  logic [mbdt_pkg::LOCK_W-1:0]    debounce_ms,
    input  logic [mbdt_pkg::KEY_W-1:0]     key,
    input  logic [mbdt_pkg::HANDLE_W-1:0]  handle,

    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           kind,
    output logic [mbdt_pkg::HANDLE_W-1:0]  button,
    output logic                           pressed,
    output logic [mbdt_pkg::TIME_W-1:0]    stamp_ms,
    output logic [mbdt_pkg::PIN_W-1:0]     event_pin,
    output logic [mbdt_pkg::KEY_W-1:0]     event_key
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK
    } state_t;

    state_t state_reg;
    logic [mbdt_pkg::IDX_W-1:0] scan_idx_reg;

    // slot table
    logic [mbdt_pkg::NUM_SLOTS-1:0] slot_used_reg;
    logic [mbdt_pkg::NUM_SLOTS-1:0] slot_down_reg;
    logic [mbdt_pkg::PIN_W-1:0]     slot_pin_reg     [mbdt_pkg::NUM_SLOTS];
    logic [mbdt_pkg::LOCK_W-1:0]    slot_lockout_reg [mbdt_pkg::NUM_SLOTS];
    logic [mbdt_pkg::KEY_W-1:0]     slot_key_reg     [mbdt_pkg::NUM_SLOTS];
    logic [mbdt_pkg::TIME_W-1:0]    slot_changed_reg [mbdt_pkg::NUM_SLOTS];

    // captured item
    logic [mbdt_pkg::MODE_W-1:0]    mode_reg;
    logic [mbdt_pkg::PIN_W-1:0]     pin_reg;
    logic                           level_reg;
    logic [mbdt_pkg::TIME_W-1:0]    now_reg;
    logic [mbdt_pkg::LOCK_W-1:0]    lockout_reg;
    logic [mbdt_pkg::KEY_W-1:0]     key_reg;

    // output word
    logic                           result_valid_reg;
    logic                           kind_reg;
    logic [mbdt_pkg::HANDLE_W-1:0]  button_reg;
    logic                           pressed_reg;
    logic [mbdt_pkg::TIME_W-1:0]    stamp_reg;
    logic [mbdt_pkg::PIN_W-1:0]     event_pin_reg;
    logic [mbdt_pkg::KEY_W-1:0]     event_key_reg;

    logic                           accept;
    logic                           out_free;
    logic                           cur_used;
    logic                           pin_match;
    logic                           scan_last;
    logic [mbdt_pkg::TIME_W:0]      elapsed;
    logic                           late;
    logic                           down;
    logic                           fire;
    logic                           is_create;
    logic                           create_done;
    logic                           wr_create;
    logic                           wr_edge;
    logic                           emit;
    logic [mbdt_pkg::HANDLE_W-1:0]  idx_handle;
    logic [mbdt_pkg::HANDLE_W-1:0]  handle_m1;
    logic                           destroy_ok;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign button       = button_reg;
    assign pressed      = pressed_reg;
    assign stamp_ms     = stamp_reg;
    assign event_pin    = event_pin_reg;
    assign event_key    = event_key_reg;

    always_comb
    begin
        out_free   = !result_valid_reg || result_ready;
        cur_used   = slot_used_reg[scan_idx_reg];
        pin_match  = (slot_pin_reg[scan_idx_reg] == pin_reg);
        scan_last  = (scan_idx_reg == mbdt_pkg::LAST_IDX);
        is_create  = (mode_reg == mbdt_pkg::MODE_CREATE);
        // borrow out of the subtract means time went backward
        elapsed    = {1'b0, now_reg} - {1'b0, slot_changed_reg[scan_idx_reg]};
        late       = !elapsed[mbdt_pkg::TIME_W]
                     && (elapsed[mbdt_pkg::TIME_W-1:0]
                         > mbdt_pkg::TIME_W'(slot_lockout_reg[scan_idx_reg]));
        down       = !level_reg;
        fire       = late && (down != slot_down_reg[scan_idx_reg]);
        create_done = (state_reg == ST_SCAN) && is_create && (!cur_used || scan_last);
        wr_create  = create_done && !cur_used && out_free;
        wr_edge    = (state_reg == ST_CHECK) && fire && out_free;
        emit       = (create_done && out_free) || wr_edge;
        idx_handle = mbdt_pkg::HANDLE_W'(scan_idx_reg) + mbdt_pkg::HANDLE_W'(1);
        handle_m1  = handle - mbdt_pkg::HANDLE_W'(1);
        destroy_ok = (handle != '0) && (handle <= mbdt_pkg::MAX_HANDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_idx_reg     <= '0;
            slot_used_reg    <= '0;
            result_valid_reg <= 1'b0;
            kind_reg         <= mbdt_pkg::KIND_EVENT;
            button_reg       <= '0;
            pressed_reg      <= 1'b0;
            stamp_reg        <= '0;
            event_pin_reg    <= '0;
            event_key_reg    <= '0;
        end
        else
        begin
            // a word drained in the same cycle as a new one lands stays valid
            if (result_valid_reg && result_ready && !emit)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        scan_idx_reg <= '0;
                        if (mode == mbdt_pkg::MODE_EDGE || mode == mbdt_pkg::MODE_CREATE)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else if (mode == mbdt_pkg::MODE_DESTROY && destroy_ok)
                        begin
                            slot_used_reg[handle_m1[mbdt_pkg::IDX_W-1:0]] <= 1'b0;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (is_create)
                    begin
                        if (create_done)
                        begin
                            if (out_free)
                            begin
                                result_valid_reg <= 1'b1;
                                kind_reg         <= mbdt_pkg::KIND_CREATE;
                                button_reg       <= cur_used ? '0 : idx_handle;
                                pressed_reg      <= 1'b0;
                                stamp_reg        <= '0;
                                event_pin_reg    <= '0;
                                event_key_reg    <= '0;
                                state_reg        <= ST_IDLE;
                                if (!cur_used)
                                begin
                                    slot_used_reg[scan_idx_reg] <= 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + mbdt_pkg::IDX_W'(1);
                        end
                    end
                    else if (cur_used && pin_match)
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else if (scan_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + mbdt_pkg::IDX_W'(1);
                    end
                end

                ST_CHECK:
                begin
                    if (!fire)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        kind_reg         <= mbdt_pkg::KIND_EVENT;
                        button_reg       <= idx_handle;
                        pressed_reg      <= down;
                        stamp_reg        <= now_reg;
                        event_pin_reg    <= slot_pin_reg[scan_idx_reg];
                        event_key_reg    <= slot_key_reg[scan_idx_reg];
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // captured item and slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            pin_reg     <= pin;
            level_reg   <= level;
            now_reg     <= now_ms;
            lockout_reg <= debounce_ms;
            key_reg     <= key;
        end
        if (wr_create)
        begin
            slot_pin_reg[scan_idx_reg]     <= pin_reg;
            slot_lockout_reg[scan_idx_reg] <= lockout_reg;
            slot_key_reg[scan_idx_reg]     <= key_reg;
            slot_down_reg[scan_idx_reg]    <= 1'b0;
            slot_changed_reg[scan_idx_reg] <= '0;
        end
        else if (wr_edge)
        begin
            slot_down_reg[scan_idx_reg]    <= down;
            slot_changed_reg[scan_idx_reg] <= now_reg;
        end
    end

`ifndef SYNTHESIS
    // a new word never lands on one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!result_valid_reg || result_ready))
        else $error("output word overwritten");

    // scan never runs past the last usable slot
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_CHECK) |-> (scan_idx_reg <= mbdt_pkg::LAST_IDX))
        else $error("scan index out of range");

    // a claimed slot is marked used and its handle is reported
    a_create_claims: assert property (@(posedge clk) disable iff (!rst_n)
        wr_create |=> (slot_used_reg[$past(scan_idx_reg)] && button_reg == $past(idx_handle)))
        else $error("create did not claim slot");

    // an event carries the edge time and updates the slot
    a_event_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        wr_edge |=> (stamp_reg == $past(now_reg)
                     && slot_changed_reg[$past(scan_idx_reg)] == $past(now_reg)
                     && kind_reg == mbdt_pkg::KIND_EVENT))
        else $error("event stamp mismatch");
`endif

endmodule

/* tb/tb_multi_button_debounce_table_unit.sv */
module tb_multi_button_debounce_table_unit;

    import mbdt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] button;
        logic                pressed;
        logic [TIME_W-1:0]   stamp;
        logic [PIN_W-1:0]    pin;
        logic [KEY_W-1:0]    key;
    } report_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    logic [MODE_W-1:0]   mode;
    logic [PIN_W-1:0]    pin;
    logic                level;
    logic [TIME_W-1:0]   now_ms;
    logic [LOCK_W-1:0]   debounce_ms;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                result_valid;
    logic                result_ready;
    logic                kind;
    logic [HANDLE_W-1:0] button;
    logic                pressed;
    logic [TIME_W-1:0]   stamp_ms;
    logic [PIN_W-1:0]    event_pin;
    logic [KEY_W-1:0]    event_key;

    // shadow copy of the slot table
    logic              tbl_used  [USABLE];
    logic [PIN_W-1:0]  tbl_pin   [USABLE];
    logic [LOCK_W-1:0] tbl_lock  [USABLE];
    logic [KEY_W-1:0]  tbl_key   [USABLE];
    logic              tbl_down  [USABLE];
    logic [TIME_W-1:0] tbl_stamp [USABLE];

    report_t           pending_reports[$];
    report_t           want;
    int                mismatches;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_left;
    int                cycle_count;
    logic [TIME_W-1:0] t_now;
    logic [PIN_W-1:0]  pin_pool[8];

    multi_button_debounce_table_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_multi_button_debounce_table_unit: errors");
        $finish;
    end

    function automatic bit next_button_report(
        input  logic [MODE_W-1:0]   m,
        input  logic [PIN_W-1:0]    p,
        input  logic                lv,
        input  logic [TIME_W-1:0]   t,
        input  logic [LOCK_W-1:0]   d,
        input  logic [KEY_W-1:0]    k,
        input  logic [HANDLE_W-1:0] h,
        output report_t             r
    );
        logic dn;
        r  = '0;
        dn = ~lv;
        if (m == MODE_CREATE)
        begin
            r.kind = KIND_CREATE;
            for (int i = 0; i < USABLE; i++)
            begin
                if (!tbl_used[i])
                begin
                    tbl_used[i]  = 1'b1;
                    tbl_pin[i]   = p;
                    tbl_lock[i]  = d;
                    tbl_key[i]   = k;
                    tbl_down[i]  = 1'b0;
                    tbl_stamp[i] = '0;
                    r.button     = HANDLE_W'(i + 1);
                    return 1'b1;
                end
            end
            return 1'b1;
        end
        if (m == MODE_DESTROY)
        begin
            if (h >= 1 && h <= MAX_HANDLE)
                tbl_used[h - 1] = 1'b0;
            return 1'b0;
        end
        if (m == MODE_EDGE)
        begin
            for (int i = 0; i < USABLE; i++)
            begin
                if (tbl_used[i] && tbl_pin[i] == p)
                begin
                    // time running backward counts as no time elapsed
                    if (t < tbl_stamp[i])
                        return 1'b0;
                    if (t - tbl_stamp[i] <= TIME_W'(tbl_lock[i]))
                        return 1'b0;
                    if (dn == tbl_down[i])
                        return 1'b0;
                    tbl_down[i]  = dn;
                    tbl_stamp[i] = t;
                    r.kind       = KIND_EVENT;
                    r.button     = HANDLE_W'(i + 1);
                    r.pressed    = dn;
                    r.stamp      = t;
                    r.pin        = tbl_pin[i];
                    r.key        = tbl_key[i];
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic int slots_in_use();
        int n;
        n = 0;
        for (int i = 0; i < USABLE; i++)
            n += int'(tbl_used[i]);
        return n;
    endfunction

    function automatic int any_used_slot();
        int idx[$];
        for (int i = 0; i < USABLE; i++)
            if (tbl_used[i])
                idx.push_back(i);
        if (idx.size() == 0)
            return -1;
        return idx[$urandom_range(idx.size() - 1)];
    endfunction

    function automatic logic [TIME_W-1:0] rnd_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    task automatic send_word(
        input logic [MODE_W-1:0]   m,
        input logic [PIN_W-1:0]    p,
        input logic                lv,
        input logic [TIME_W-1:0]   t,
        input logic [LOCK_W-1:0]   d,
        input logic [KEY_W-1:0]    k,
        input logic [HANDLE_W-1:0] h
    );
        report_t r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        mode        = m;
        pin         = p;
        level       = lv;
        now_ms      = t;
        debounce_ms = d;
        key         = k;
        handle      = h;
        item_valid  = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (next_button_report(m, p, lv, t, d, k, h, r))
            pending_reports.push_back(r);
    endtask

    // shorthands with random don't-care fields
    task automatic send_create(input logic [PIN_W-1:0] p, input logic [LOCK_W-1:0] d,
                               input logic [KEY_W-1:0] k);
        send_word(MODE_CREATE, p, 1'($urandom), rnd_time(), d, k, HANDLE_W'($urandom));
    endtask

    task automatic send_destroy(input logic [HANDLE_W-1:0] h);
        send_word(MODE_DESTROY, PIN_W'($urandom), 1'($urandom), rnd_time(),
                  LOCK_W'($urandom), KEY_W'($urandom), h);
    endtask

    task automatic send_edge(input logic [PIN_W-1:0] p, input logic lv,
                             input logic [TIME_W-1:0] t);
        send_word(MODE_EDGE, p, lv, t, LOCK_W'($urandom), KEY_W'($urandom),
                  HANDLE_W'($urandom));
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (mismatches < 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, exp_v,
                     act_v);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                note_mismatch("unexpected word, button", '0, 64'(button));
            end
            else
            begin
                want = pending_reports.pop_front();
                if (kind !== want.kind)
                    note_mismatch("kind", 64'(want.kind), 64'(kind));
                if (button !== want.button)
                    note_mismatch("button", 64'(want.button), 64'(button));
                if (pressed !== want.pressed)
                    note_mismatch("pressed", 64'(want.pressed), 64'(pressed));
                if (stamp_ms !== want.stamp)
                    note_mismatch("stamp_ms", 64'(want.stamp), 64'(stamp_ms));
                if (event_pin !== want.pin)
                    note_mismatch("event_pin", 64'(want.pin), 64'(event_pin));
                if (event_key !== want.key)
                    note_mismatch("event_key", 64'(want.key), 64'(event_key));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready = 1'b0;
                hold_left--;
            end
            else
            begin
                result_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idle(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    task automatic test_empty_table();
        send_edge(6'd5, 1'b0, 40'd100);
        send_destroy('0);
        send_destroy(6'd63);
        send_destroy(6'd1);
        send_word(MODE_UNUSED, PIN_W'($urandom), 1'($urandom), rnd_time(),
                  LOCK_W'($urandom), KEY_W'($urandom), HANDLE_W'($urandom));
    endtask

    task automatic test_lockout_edges();
        send_create(6'd0, 16'hFFFF, 16'hFFFF);
        send_create(6'd63, 16'h0000, 16'h0000);
        send_edge(6'd0, 1'b0, 40'd65535);            // elapsed equals lockout
        send_edge(6'd0, 1'b0, 40'd65536);            // press
        send_edge(6'd63, 1'b1, 40'd1);               // level unchanged
        send_edge(6'd63, 1'b0, 40'd1);               // press, zero lockout
        send_edge(6'd63, 1'b1, 40'd0);               // time went backward
        send_edge(6'd63, 1'b1, 40'hFF_FFFF_FFFF);    // release at max time
        send_create(6'd63, 16'd5, 16'h1234);         // same pin, shadowed by slot 2
        send_edge(6'd63, 1'b0, 40'hFF_FFFF_FFFF);    // hits slot 2, no time left
        send_destroy(6'd2);
        send_edge(6'd63, 1'b0, 40'd5);               // slot 3, inside lockout
        send_edge(6'd63, 1'b0, 40'd6);               // slot 3 press
        send_edge(6'd0, 1'b1, 40'd131073);           // slot 1 release
        send_edge(6'd42, 1'b0, 40'd200000);          // no slot with this pin
    endtask

    task automatic test_table_full();
        while (slots_in_use() < USABLE)
            send_create(PIN_W'($urandom), LOCK_W'($urandom), KEY_W'($urandom));
        send_create(PIN_W'($urandom), LOCK_W'($urandom), KEY_W'($urandom));
        for (int h = USABLE; h >= 1; h--)
            send_destroy(HANDLE_W'(h));
    endtask

    task automatic random_word();
        int                  r;
        int                  s;
        int                  cnt;
        logic [PIN_W-1:0]    p;
        logic                lv;
        logic [LOCK_W-1:0]   d;
        logic [HANDLE_W-1:0] h;
        r   = $urandom_range(99);
        cnt = slots_in_use();
        s   = any_used_slot();
        if (r < 4)
        begin
            send_word(MODE_UNUSED, PIN_W'($urandom), 1'($urandom), rnd_time(),
                      LOCK_W'($urandom), KEY_W'($urandom), HANDLE_W'($urandom));
        end
        else if (cnt < 4 || (r < 14 && cnt < 30))
        begin
            d = ($urandom_range(9) == 0) ? LOCK_W'($urandom) : LOCK_W'($urandom_range(20));
            p = ($urandom_range(9) == 0) ? PIN_W'($urandom) : pin_pool[$urandom_range(7)];
            send_create(p, d, KEY_W'($urandom));
        end
        else if (r < 22 || cnt > 28)
        begin
            h = (s >= 0 && $urandom_range(9) < 8) ? HANDLE_W'(s + 1) : HANDLE_W'($urandom);
            send_destroy(h);
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 2)
                t_now = rnd_time();
            else if (r < 4)
                t_now = t_now - TIME_W'($urandom_range(1, 50));
            else
                t_now = t_now + TIME_W'($urandom_range(25));
            if (s >= 0 && $urandom_range(9) < 8)
            begin
                p  = tbl_pin[s];
                // mostly drive the level that flips the debounced state
                lv = ($urandom_range(9) < 7) ? tbl_down[s] : 1'($urandom);
            end
            else
            begin
                p  = PIN_W'($urandom);
                lv = 1'($urandom);
            end
            send_edge(p, lv, t_now);
        end
    endtask

    task automatic test_random_traffic(input int n);
        for (int i = 0; i < 8; i++)
            pin_pool[i] = PIN_W'($urandom);
        repeat (n)
            random_word();
    endtask

    task automatic test_receiver_hold();
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        repeat (6)
        begin
            send_create(pin_pool[$urandom_range(7)], LOCK_W'($urandom_range(20)),
                        KEY_W'($urandom));
            send_destroy(HANDLE_W'(any_used_slot() + 1));
        end
        repeat (10)
            random_word();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        mode        = MODE_EDGE;
        pin         = '0;
        level       = 1'b1;
        now_ms      = '0;
        debounce_ms = '0;
        key         = '0;
        handle      = '0;
        mismatches  = 0;
        hold_left   = 0;
        t_now       = 40'd1000;
        set_idle(0, 0);
        for (int i = 0; i < USABLE; i++)
        begin
            tbl_used[i]  = 1'b0;
            tbl_pin[i]   = '0;
            tbl_lock[i]  = '0;
            tbl_key[i]   = '0;
            tbl_down[i]  = 1'b0;
            tbl_stamp[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            pin_pool[i] = PIN_W'(i);
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_lockout_edges();
        test_table_full();
        set_idle(86, 0);
        test_random_traffic(110);
        set_idle(0, 86);
        test_random_traffic(110);
        set_idle(0, 0);
        test_receiver_hold();
        set_idle(18, 18);
        test_random_traffic(110);
        set_idle(0, 0);
        test_random_traffic(110);

        @(negedge clk);
        item_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (USABLE + 8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_multi_button_debounce_table_unit: clean");
        else
            $display("tb_multi_button_debounce_table_unit: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/mbdt_pkg.sv
rtl/core/multi_button_debounce_table_unit.sv
tb/tb_multi_button_debounce_table_unit.sv
